/* sv/bcg_pkg.sv */
`default_nettype none

package bcg_pkg;

    // Input queue depth between the front and back ends.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths.
    localparam int ADC_W   = 12;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_NUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_DEN = 1'b1;

    localparam logic [CFG_W-1:0] DIVIDER_NUM_RST = 8'd2;
    localparam logic [CFG_W-1:0] DIVIDER_DEN_RST = 8'd1;

    // ADC reference in millivolts.
    localparam logic [ADC_W-1:0] VREF_MV = 12'd3300;

    // Shared divider operand widths.
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 20;
    localparam int DIV_Q_W = 16;
    localparam int DIV_CNT_W = 5;

    // Discharge curve, one entry per segment.
    localparam int GAUGE_SEGS = 10;
    localparam int SEG_W      = 4;
    localparam logic [MV_W-1:0]  MV_LOW   = 16'd3300;
    localparam logic [MV_W-1:0]  MV_HIGH  = 16'd4200;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [MV_W-1:0] SEG_X0 [0:GAUGE_SEGS-1] = '{
        16'd3300, 16'd3450, 16'd3550, 16'd3650, 16'd3720,
        16'd3780, 16'd3850, 16'd3920, 16'd4000, 16'd4100
    };
    localparam logic [MV_W-1:0] SEG_X1 [0:GAUGE_SEGS-1] = '{
        16'd3450, 16'd3550, 16'd3650, 16'd3720, 16'd3780,
        16'd3850, 16'd3920, 16'd4000, 16'd4100, 16'd4200
    };

    // Reciprocal of each segment width, 2^24 / width rounded up. The products that get
    // scaled stay far below the point where this would differ from a true division.
    localparam int RCP_W     = 19;
    localparam int RCP_SHIFT = 24;
    localparam logic [RCP_W-1:0] SEG_RCP [0:GAUGE_SEGS-1] = '{
        19'd111849, 19'd167773, 19'd167773, 19'd239675, 19'd279621,
        19'd239675, 19'd239675, 19'd209716, 19'd167773, 19'd167773
    };
    localparam logic [PCT_W-1:0] SEG_Y0 [0:GAUGE_SEGS-1] = '{
        7'd0,  7'd5,  7'd12, 7'd25, 7'd40,
        7'd55, 7'd70, 7'd82, 7'd92, 7'd98
    };
    localparam logic [3:0] SEG_DY [0:GAUGE_SEGS-1] = '{
        4'd5,  4'd7,  4'd13, 4'd15, 4'd15,
        4'd15, 4'd12, 4'd10, 4'd6,  4'd2
    };

    typedef struct packed {
        logic [ADC_W-1:0] adc_value;
        logic             charging;
        logic             sample_ok;
    } sample_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/bcg_front.sv */
`default_nettype none

module bcg_front
    import bcg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [ADC_W-1:0] adc_value,
    input  wire logic             charging,
    input  wire logic             sample_ok,
    output logic                  q_valid,
    output sample_t               q_item,
    input  wire logic             q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sample_t          slot_reg [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;
    sample_t          item;

    // A faulted sample carries only its class; its other fields are cleared.
    always_comb
    begin
        item.sample_ok = sample_ok;
        item.charging  = sample_ok & charging;
        item.adc_value = sample_ok ? adc_value : '0;
    end

    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid & ~in_stall;
    assign pop      = q_pop & q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

/* sv/bcg_div.sv */
`default_nettype none

module bcg_div
    import bcg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   low_reg, low_next;
    logic [DIV_Q_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W:0]     trial;
    logic                 take;
    logic                 overflow;

    // The quotient saturates when it would not fit; a zero divisor lands here too.
    assign overflow = {{(DIV_D_W + DIV_Q_W - DIV_N_W){1'b0}}, req.dividend}
                      >= {req.divisor, {DIV_Q_W{1'b0}}};
    assign trial    = {rem_reg, low_reg[DIV_Q_W-1]};
    assign take     = trial >= {1'b0, req.divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            if (overflow)
            begin
                quo_next  = '1;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {{(DIV_D_W - (DIV_N_W - DIV_Q_W)){1'b0}},
                             req.dividend[DIV_N_W-1:DIV_Q_W]};
                low_next  = req.dividend[DIV_Q_W-1:0];
                quo_next  = '0;
                cnt_next  = DIV_CNT_W'(DIV_Q_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = take ? DIV_D_W'(trial - {1'b0, req.divisor}) : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_Q_W-2:0], take};
            low_next = {low_reg[DIV_Q_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/bcg_back.sv */
`default_nettype none

module bcg_back
    import bcg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CFG_W-1:0] divider_num,
    input  wire logic [CFG_W-1:0] divider_den,
    input  wire logic             q_valid,
    input  wire sample_t          q_item,
    output logic                  q_pop,
    output div_req_t              div_req,
    input  wire div_rsp_t         div_rsp,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [MV_W-1:0]       battery_mv,
    output logic [PCT_W-1:0]      percent,
    output logic                  is_charging,
    output logic                  reading_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_DIVA  = 4'd3;
    localparam logic [3:0] S_WAITA = 4'd4;
    localparam logic [3:0] S_FILT  = 4'd5;
    localparam logic [3:0] S_SEG   = 4'd6;
    localparam logic [3:0] S_MULP  = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_HYST  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [MV_W-1:0]    last_mv_reg, last_mv_next;
    logic [PCT_W-1:0]   last_pct_reg, last_pct_next;

    logic [ADC_W-1:0]   adc_reg, adc_next;
    logic               chg_reg, chg_next;
    logic               res_ok_reg, res_ok_next;
    logic [23:0]        prod1_reg, prod1_next;
    logic [31:0]        top_reg, top_next;
    logic [MV_W-1:0]    mv_reg, mv_next;
    logic [MV_W-1:0]    filt_reg, filt_next;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [11:0]        prodp_reg, prodp_next;
    logic [PCT_W-1:0]   est_reg, est_next;
    logic [PCT_W-1:0]   res_pct_reg, res_pct_next;
    logic [MV_W-1:0]    out_mv_reg, out_mv_next;
    logic [PCT_W-1:0]   out_pct_reg, out_pct_next;
    logic               out_chg_reg, out_chg_next;
    logic               out_ok_reg, out_ok_next;

    logic [DIV_D_W-1:0] bot;
    logic [17:0]        blend;
    logic [SEG_W-1:0]   seg_found;
    logic [7:0]         dmv;
    logic [30:0]        scaled;
    logic               rise;
    logic               fall;

    // 4095 * den as a shift and subtract.
    assign bot   = {divider_den, 12'b0} - {12'b0, divider_den};
    assign blend = {last_mv_reg, 1'b0} + {2'b0, last_mv_reg} + {2'b0, mv_reg};
    assign dmv   = 8'(filt_reg - SEG_X0[seg_reg]);
    // Division by the segment width as a multiply by its reciprocal.
    assign scaled = {19'b0, prodp_reg} * {12'b0, SEG_RCP[seg_reg]};
    assign rise  = {1'b0, est_reg} > ({1'b0, last_pct_reg} + 8'd1);
    assign fall  = {1'b0, last_pct_reg} > ({1'b0, est_reg} + 8'd1);

    // First segment whose upper end is at or above the filtered value.
    always_comb
    begin
        seg_found = SEG_W'(GAUGE_SEGS - 1);
        for (int k = GAUGE_SEGS - 1; k >= 0; k--)
        begin
            if (filt_reg <= SEG_X1[k])
            begin
                seg_found = SEG_W'(k);
            end
        end
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // The divisor follows the ratio register and stays steady only while it is not written.
    always_comb
    begin
        div_req.start    = (state_reg == S_DIVA);
        div_req.dividend = top_reg + {13'b0, bot[DIV_D_W-1:1]};
        div_req.divisor  = bot;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        last_mv_next   = last_mv_reg;
        last_pct_next  = last_pct_reg;
        adc_next       = adc_reg;
        chg_next       = chg_reg;
        res_ok_next    = res_ok_reg;
        prod1_next     = prod1_reg;
        top_next       = top_reg;
        mv_next        = mv_reg;
        filt_next      = filt_reg;
        seg_next       = seg_reg;
        prodp_next     = prodp_reg;
        est_next       = est_reg;
        res_pct_next   = res_pct_reg;
        out_mv_next    = out_mv_reg;
        out_pct_next   = out_pct_reg;
        out_chg_next   = out_chg_reg;
        out_ok_next    = out_ok_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    adc_next    = q_item.adc_value;
                    chg_next    = q_item.charging;
                    res_ok_next = q_item.sample_ok;
                    if (q_item.sample_ok)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        filt_next    = '0;
                        res_pct_next = '0;
                        state_next   = S_FIN;
                    end
                end
            end
            S_MUL1:
            begin
                prod1_next = {12'b0, adc_reg} * {12'b0, VREF_MV};
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                top_next   = {8'b0, prod1_reg} * {24'b0, divider_num};
                state_next = S_DIVA;
            end
            S_DIVA:
            begin
                state_next = S_WAITA;
            end
            S_WAITA:
            begin
                if (div_rsp.done)
                begin
                    mv_next    = div_rsp.quotient;
                    state_next = S_FILT;
                end
            end
            S_FILT:
            begin
                filt_next  = (last_mv_reg == '0) ? mv_reg : blend[17:2];
                state_next = S_SEG;
            end
            S_SEG:
            begin
                seg_next = seg_found;
                if (filt_reg <= MV_LOW)
                begin
                    est_next   = '0;
                    state_next = S_HYST;
                end
                else if (filt_reg > MV_HIGH)
                begin
                    est_next   = PCT_FULL;
                    state_next = S_HYST;
                end
                else
                begin
                    state_next = S_MULP;
                end
            end
            S_MULP:
            begin
                prodp_next = {4'b0, dmv} * {8'b0, SEG_DY[seg_reg]};
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                est_next   = SEG_Y0[seg_reg] + {3'b0, scaled[RCP_SHIFT+3:RCP_SHIFT]};
                state_next = S_HYST;
            end
            S_HYST:
            begin
                if (last_mv_reg == '0)
                begin
                    res_pct_next = est_reg;
                end
                else if (chg_reg)
                begin
                    res_pct_next = rise ? est_reg : last_pct_reg;
                end
                else
                begin
                    res_pct_next = fall ? est_reg : last_pct_reg;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_mv_next    = filt_reg;
                    out_pct_next   = res_pct_reg;
                    out_chg_next   = chg_reg;
                    out_ok_next    = res_ok_reg;
                    if (res_ok_reg)
                    begin
                        last_mv_next  = filt_reg;
                        last_pct_next = res_pct_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_mv_reg   <= '0;
            last_pct_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            last_mv_reg   <= last_mv_next;
            last_pct_reg  <= last_pct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adc_reg     <= adc_next;
        chg_reg     <= chg_next;
        res_ok_reg  <= res_ok_next;
        prod1_reg   <= prod1_next;
        top_reg     <= top_next;
        mv_reg      <= mv_next;
        filt_reg    <= filt_next;
        seg_reg     <= seg_next;
        prodp_reg   <= prodp_next;
        est_reg     <= est_next;
        res_pct_reg <= res_pct_next;
        out_mv_reg  <= out_mv_next;
        out_pct_reg <= out_pct_next;
        out_chg_reg <= out_chg_next;
        out_ok_reg  <= out_ok_next;
    end

    assign out_valid     = out_valid_reg;
    assign battery_mv    = out_mv_reg;
    assign percent       = out_pct_reg;
    assign is_charging   = out_chg_reg;
    assign reading_valid = out_ok_reg;

endmodule

`default_nettype wire

/* sv/battery_charge_gauge_core.sv */
// Battery charge gauge. Each input transfer carries one averaged ADC reading with a
// charging flag and a sample-ok flag; each produces exactly one output transfer with the
// filtered millivolts, the state of charge in percent, the echoed charging flag and a
// reading-valid flag. A faulted sample gives an all-zero result and leaves the state alone.
// Both channels use valid/stall: a transfer happens on a rising edge with valid high and
// stall low. Inputs land in a small queue, so the sender is stalled only when it is full.
// For a good sample the radix-2 divider spends 16 steps on the millivolt conversion, and
// the curve interpolation uses a reciprocal multiply. A value off either end of the curve
// skips the multiply, and a faulted sample skips all the arithmetic. The back end takes a
// queued sample only once the last result is in the output register. While the receiver
// stalls, the result holds there, the back end waits with the next result finished, and
// the queue keeps taking transfers until it fills. Reset (rst_n, asynchronous, active
// low) empties the queue and the output, clears the stored voltage and percentage, and
// loads divider ratio 2/1. The user must write the divider ratio registers only while
// the block is idle, through cfg_we/cfg_index/cfg_wdata; the block does not enforce it.
`default_nettype none

module battery_charge_gauge_core
    import bcg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ADC_W-1:0]     adc_value,
    input  wire logic                 charging,
    input  wire logic                 sample_ok,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [MV_W-1:0]           battery_mv,
    output logic [PCT_W-1:0]          percent,
    output logic                      is_charging,
    output logic                      reading_valid,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] divider_num_reg, divider_num_next;
    logic [CFG_W-1:0] divider_den_reg, divider_den_next;
    logic             q_valid;
    sample_t          q_item;
    logic             q_pop;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    // Divider ratio registers; a zero denominator makes the conversion saturate.
    always_comb
    begin
        divider_num_next = divider_num_reg;
        divider_den_next = divider_den_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIVIDER_NUM: divider_num_next = cfg_wdata;
                REG_DIVIDER_DEN: divider_den_next = cfg_wdata;
                default:         divider_num_next = divider_num_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_num_reg <= DIVIDER_NUM_RST;
            divider_den_reg <= DIVIDER_DEN_RST;
        end
        else
        begin
            divider_num_reg <= divider_num_next;
            divider_den_reg <= divider_den_next;
        end
    end

    // The front end takes transfers and tags faulted samples.
    bcg_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .adc_value (adc_value),
        .charging  (charging),
        .sample_ok (sample_ok),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // The divider handles the millivolt conversion through the configured ratio.
    bcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The back end sequences the arithmetic and owns the result register.
    bcg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .divider_num   (divider_num_reg),
        .divider_den   (divider_den_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .battery_mv    (battery_mv),
        .percent       (percent),
        .is_charging   (is_charging),
        .reading_valid (reading_valid)
    );

    // A published percentage never exceeds full charge.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (percent <= PCT_FULL))
    else $error("percent above full charge");

    // A faulted result carries no measurement at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reading_valid) |->
        ((battery_mv == '0) && (percent == '0) && !is_charging))
    else $error("fault result with nonzero fields");

    // The divider start request is never held high on consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_req.start)
    else $error("divider started on two cycles in a row");

endmodule

`default_nettype wire
